### rtl/imhit_pkg.sv
// ----------------------------------------------------------------------------
// imhit_pkg
// Shared types and constants for the image map region hit test.
// ----------------------------------------------------------------------------
package imhit_pkg;

  localparam int COORD_W    = 16;  // signed pixel coordinate
  localparam int ID_W       = 12;  // region identifier
  localparam int OP_W       = 3;   // operation code
  localparam int CFG_IDX_W  = 1;   // config register index
  localparam int CFG_DATA_W = 16;  // config write data
  localparam int DIFF_W     = COORD_W + 1;  // coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;   // product of two differences
  localparam int SQ_W       = 32;           // squared distance term

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_DEFAULT = 3'd0,
    OP_RECT    = 3'd1,
    OP_CIRCLE  = 3'd2,
    OP_VERTEX  = 3'd3,
    OP_FINISH  = 3'd4
  } op_e;

  // Per-item control carried down the pipe
  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
    logic            last;
    logic            poly_start;  // vertex opens a new polygon
  } ctl_t;

  // One polygon edge, first end to second end
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } seg_t;

  // Edge test outcome
  typedef struct packed {
    logic toggle;   // flips crossing parity
    logic on_line;  // point lies on a horizontal edge
  } cross_t;

endpackage

### rtl/image_map_region_hit_test_top.sv
// ----------------------------------------------------------------------------
// image_map_region_hit_test_top
// Tests a configured point against a stream of map regions (default,
// rectangle, circle, polygon vertex) and reports the winning region on finish.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+-----------------------
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i          | point_x / point_y write
//  input    | in_valid_i / in_ready_o + item fields     | one region or command
//  output   | out_valid_o / out_ready_i + result fields | one result per finish
//
//  One item per cycle sustained unless a finish item stalls. Pipeline: input
//  register, product stage, decision stage, then the match state update that
//  loads the result register for a finish item.
//  A result waiting in the output register stalls only a later finish item
//  that reaches the decision stage; other items keep flowing, bubbles
//  collapse, and in_ready_o drops only once the pipe is full behind it.
//  Reset clears match, polygon and valid state and sets the point to 0,0.
//
module image_map_region_hit_test_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [imhit_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [imhit_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input items
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [imhit_pkg::OP_W-1:0]             operation_i,
  input  logic signed [imhit_pkg::COORD_W-1:0]   ax_i,
  input  logic signed [imhit_pkg::COORD_W-1:0]   ay_i,
  input  logic signed [imhit_pkg::COORD_W-1:0]   bx_i,
  input  logic signed [imhit_pkg::COORD_W-1:0]   by_i,
  input  logic [imhit_pkg::ID_W-1:0]             region_id_i,
  input  logic                                   last_vertex_i,
  // results
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   found_o,
  output logic [imhit_pkg::ID_W-1:0]             hit_region_o,
  output logic                                   from_default_o
);

  // Point under test. User must write it only while idle so every stage sees it stable; the block does not check it.
  logic signed [imhit_pkg::COORD_W-1:0] point_x_q, point_y_q;

  // Stage 1 (input register) outputs
  logic                                 v1;
  imhit_pkg::ctl_t                      ctl1;
  logic signed [imhit_pkg::COORD_W-1:0] ax1, ay1, bx1, by1;
  imhit_pkg::seg_t                      seg0_1, seg1_1;

  // Control for stages 2 and 3; payload lives inside the units
  logic                                 v2_q, v3_q;
  imhit_pkg::ctl_t                      ctl2_q, ctl3_q;

  // Handshake chain: a stage may load when empty or when its item moves on
  logic                                 fire3, rdy1, rdy2, rdy3, in_fire;
  logic                                 out_free;

  imhit_pkg::cross_t                    cross0, cross1;
  logic                                 shape_hit;

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q <= '0;
      point_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imhit_pkg::REG_POINT_X: point_x_q <= $signed(cfg_wdata_i);
        imhit_pkg::REG_POINT_Y: point_y_q <= $signed(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  // ---- flow control ----
  // Only a finish item needs the result register; everything else retires.
  assign fire3      = v3_q && ((ctl3_q.op != imhit_pkg::OP_FINISH) || out_free);
  assign rdy3       = !v3_q || fire3;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign in_ready_o = rdy1;
  assign in_fire    = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= v1;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      ctl2_q <= ctl1;
    end
    if (rdy3) begin
      ctl3_q <= ctl2_q;
    end
  end

  // ---- stage 1: input register, polygon edge formation ----
  imhit_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (rdy1),
    .in_fire_i     (in_fire),
    .operation_i   (operation_i),
    .ax_i          (ax_i),
    .ay_i          (ay_i),
    .bx_i          (bx_i),
    .by_i          (by_i),
    .region_id_i   (region_id_i),
    .last_vertex_i (last_vertex_i),
    .s1_valid_o    (v1),
    .s1_ctl_o      (ctl1),
    .s1_ax_o       (ax1),
    .s1_ay_o       (ay1),
    .s1_bx_o       (bx1),
    .s1_by_o       (by1),
    .s1_seg0_o     (seg0_1),
    .s1_seg1_o     (seg1_1)
  );

  // ---- stages 2 and 3: both edges of a vertex in parallel ----
  // seg0: previous vertex to this one; seg1: closing edge on the last vertex
  imhit_seg u_seg0 (
    .clk_i     (clk_i),
    .en2_i     (rdy2),
    .en3_i     (rdy3),
    .point_x_i (point_x_q),
    .point_y_i (point_y_q),
    .seg_i     (seg0_1),
    .cross_o   (cross0)
  );

  imhit_seg u_seg1 (
    .clk_i     (clk_i),
    .en2_i     (rdy2),
    .en3_i     (rdy3),
    .point_x_i (point_x_q),
    .point_y_i (point_y_q),
    .seg_i     (seg1_1),
    .cross_o   (cross1)
  );

  // ---- stages 2-3: rectangle / circle ----
  imhit_shape u_shape (
    .clk_i     (clk_i),
    .en2_i     (rdy2),
    .en3_i     (rdy3),
    .point_x_i (point_x_q),
    .point_y_i (point_y_q),
    .op_i      (ctl1.op),
    .ax_i      (ax1),
    .ay_i      (ay1),
    .bx_i      (bx1),
    .by_i      (by1),
    .hit_o     (shape_hit)
  );

  // ---- match state update and result register ----
  imhit_match u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire3),
    .ctl_i          (ctl3_q),
    .cross0_i       (cross0),
    .cross1_i       (cross1),
    .shape_hit_i    (shape_hit),
    .out_ready_i    (out_ready_i),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .found_o        (found_o),
    .hit_region_o   (hit_region_o),
    .from_default_o (from_default_o)
  );

endmodule

### rtl/imhit_front.sv
// ----------------------------------------------------------------------------
// imhit_front
// Input register and polygon vertex tracking; forms the edges of each vertex.
// ----------------------------------------------------------------------------
module imhit_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   load_i,
  input  logic                                   in_fire_i,
  input  logic [imhit_pkg::OP_W-1:0]             operation_i,
  input  logic signed [imhit_pkg::COORD_W-1:0]   ax_i,
  input  logic signed [imhit_pkg::COORD_W-1:0]   ay_i,
  input  logic signed [imhit_pkg::COORD_W-1:0]   bx_i,
  input  logic signed [imhit_pkg::COORD_W-1:0]   by_i,
  input  logic [imhit_pkg::ID_W-1:0]             region_id_i,
  input  logic                                   last_vertex_i,
  output logic                                   s1_valid_o,
  output imhit_pkg::ctl_t                        s1_ctl_o,
  output logic signed [imhit_pkg::COORD_W-1:0]   s1_ax_o,
  output logic signed [imhit_pkg::COORD_W-1:0]   s1_ay_o,
  output logic signed [imhit_pkg::COORD_W-1:0]   s1_bx_o,
  output logic signed [imhit_pkg::COORD_W-1:0]   s1_by_o,
  output imhit_pkg::seg_t                        s1_seg0_o,
  output imhit_pkg::seg_t                        s1_seg1_o
);

  imhit_pkg::op_e                      op;
  logic                                op_ok;
  logic                                is_vertex;
  logic                                start;
  logic [imhit_pkg::COORD_W-1:0]       first_x;
  logic [imhit_pkg::COORD_W-1:0]       first_y;
  logic                                poly_open_q, poly_open_d;
  logic [imhit_pkg::COORD_W-1:0]       first_x_q, first_y_q;
  logic [imhit_pkg::COORD_W-1:0]       prev_x_q, prev_y_q;
  logic                                s1_valid_q;
  imhit_pkg::ctl_t                     ctl_d, ctl_q;
  imhit_pkg::seg_t                     seg0_d, seg1_d, seg0_q, seg1_q;
  logic signed [imhit_pkg::COORD_W-1:0] ax_q, ay_q, bx_q, by_q;

  assign op        = imhit_pkg::op_e'(operation_i);
  assign op_ok     = (operation_i <= imhit_pkg::OP_FINISH);
  assign is_vertex = (op == imhit_pkg::OP_VERTEX);
  assign start     = !poly_open_q;
  assign first_x   = start ? ax_i : first_x_q;
  assign first_y   = start ? ay_i : first_y_q;

  always_comb begin
    // edge from previous vertex to this one
    seg0_d.valid = is_vertex && poly_open_q;
    seg0_d.x1    = prev_x_q;
    seg0_d.y1    = prev_y_q;
    seg0_d.x2    = ax_i;
    seg0_d.y2    = ay_i;
    // closing edge back to the first vertex
    seg1_d.valid = is_vertex && last_vertex_i;
    seg1_d.x1    = ax_i;
    seg1_d.y1    = ay_i;
    seg1_d.x2    = first_x;
    seg1_d.y2    = first_y;

    ctl_d.op         = op;
    ctl_d.id         = region_id_i;
    ctl_d.last       = last_vertex_i;
    ctl_d.poly_start = start;
  end

  // any other shape or a finish abandons an open polygon
  always_comb begin
    poly_open_d = poly_open_q;
    if (in_fire_i && op_ok) begin
      poly_open_d = is_vertex && !last_vertex_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_open_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      poly_open_q <= poly_open_d;
      if (load_i) begin
        s1_valid_q <= in_fire_i && op_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i && is_vertex) begin
      first_x_q <= first_x;
      first_y_q <= first_y;
      prev_x_q  <= ax_i;
      prev_y_q  <= ay_i;
    end
    if (in_fire_i) begin
      ctl_q  <= ctl_d;
      seg0_q <= seg0_d;
      seg1_q <= seg1_d;
      ax_q   <= ax_i;
      ay_q   <= ay_i;
      bx_q   <= bx_i;
      by_q   <= by_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_ctl_o   = ctl_q;
  assign s1_ax_o    = ax_q;
  assign s1_ay_o    = ay_q;
  assign s1_bx_o    = bx_q;
  assign s1_by_o    = by_q;
  assign s1_seg0_o  = seg0_q;
  assign s1_seg1_o  = seg1_q;

endmodule

### rtl/imhit_seg.sv
// ----------------------------------------------------------------------------
// imhit_seg
// Two-stage crossing test of one polygon edge against the point's row.
// ----------------------------------------------------------------------------
module imhit_seg (
  input  logic                                 clk_i,
  input  logic                                 en2_i,
  input  logic                                 en3_i,
  input  logic signed [imhit_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [imhit_pkg::COORD_W-1:0] point_y_i,
  input  imhit_pkg::seg_t                      seg_i,
  output imhit_pkg::cross_t                    cross_o
);

  logic signed [imhit_pkg::COORD_W-1:0] x1, y1, x2, y2;
  logic signed [imhit_pkg::DIFF_W-1:0]  dx_p, dy_e, dx_e, dy_p;
  logic signed [imhit_pkg::PROD_W-1:0]  lhs, rhs;
  logic straddle, right_both, left_both, horiz, between;

  logic                                 valid_q;
  logic                                 straddle_q, right_both_q, left_both_q;
  logic                                 horiz_q, between_q, dy_pos_q;
  logic signed [imhit_pkg::PROD_W-1:0]  lhs_q, rhs_q;
  logic                                 right;
  imhit_pkg::cross_t                    cross_d, cross_q;

  assign x1 = $signed(seg_i.x1);
  assign y1 = $signed(seg_i.y1);
  assign x2 = $signed(seg_i.x2);
  assign y2 = $signed(seg_i.y2);

  // exact 17-bit differences
  assign dx_p = $signed({point_x_i[imhit_pkg::COORD_W-1], point_x_i})
              - $signed({x1[imhit_pkg::COORD_W-1], x1});
  assign dy_p = $signed({point_y_i[imhit_pkg::COORD_W-1], point_y_i})
              - $signed({y1[imhit_pkg::COORD_W-1], y1});
  assign dx_e = $signed({x2[imhit_pkg::COORD_W-1], x2})
              - $signed({x1[imhit_pkg::COORD_W-1], x1});
  assign dy_e = $signed({y2[imhit_pkg::COORD_W-1], y2})
              - $signed({y1[imhit_pkg::COORD_W-1], y1});

  // intercept test by cross-multiplication, operands sign-extended
  assign lhs = $signed({{imhit_pkg::DIFF_W{dx_p[imhit_pkg::DIFF_W-1]}}, dx_p})
             * $signed({{imhit_pkg::DIFF_W{dy_e[imhit_pkg::DIFF_W-1]}}, dy_e});
  assign rhs = $signed({{imhit_pkg::DIFF_W{dx_e[imhit_pkg::DIFF_W-1]}}, dx_e})
             * $signed({{imhit_pkg::DIFF_W{dy_p[imhit_pkg::DIFF_W-1]}}, dy_p});

  assign straddle   = ((y1 <= point_y_i) && (y2 > point_y_i))
                   || ((y1 >= point_y_i) && (y2 < point_y_i));
  assign right_both = (point_x_i >= x1) && (point_x_i >= x2);
  assign left_both  = (point_x_i < x1) && (point_x_i < x2);
  assign horiz      = (y1 == y2) && (point_y_i == y1);
  assign between    = ((point_x_i >= x1) && (point_x_i <= x2))
                   || ((point_x_i <= x1) && (point_x_i >= x2));

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      valid_q      <= seg_i.valid;
      straddle_q   <= straddle;
      right_both_q <= right_both;
      left_both_q  <= left_both;
      horiz_q      <= horiz;
      between_q    <= between;
      dy_pos_q     <= (y2 > y1);
      lhs_q        <= lhs;
      rhs_q        <= rhs;
    end
  end

  assign right = dy_pos_q ? (lhs_q >= rhs_q) : (lhs_q <= rhs_q);

  always_comb begin
    cross_d.toggle  = 1'b0;
    cross_d.on_line = 1'b0;
    if (valid_q) begin
      if (straddle_q) begin
        cross_d.toggle = right_both_q || (!left_both_q && right);
      end else if (horiz_q) begin
        cross_d.on_line = between_q;
        cross_d.toggle  = !between_q && right_both_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      cross_q <= cross_d;
    end
  end

  assign cross_o = cross_q;

endmodule

### rtl/imhit_shape.sv
// ----------------------------------------------------------------------------
// imhit_shape
// Two-stage rectangle and circle containment test.
// ----------------------------------------------------------------------------
module imhit_shape (
  input  logic                                 clk_i,
  input  logic                                 en2_i,
  input  logic                                 en3_i,
  input  logic signed [imhit_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [imhit_pkg::COORD_W-1:0] point_y_i,
  input  imhit_pkg::op_e                       op_i,
  input  logic signed [imhit_pkg::COORD_W-1:0] ax_i,
  input  logic signed [imhit_pkg::COORD_W-1:0] ay_i,
  input  logic signed [imhit_pkg::COORD_W-1:0] bx_i,
  input  logic signed [imhit_pkg::COORD_W-1:0] by_i,
  output logic                                 hit_o
);

  logic signed [imhit_pkg::COORD_W-1:0] lx, hx, ly, hy;
  logic                                 rect_hit;
  logic signed [imhit_pkg::DIFF_W-1:0]  dx, dy;
  logic signed [imhit_pkg::PROD_W-1:0]  dx_sq, dy_sq;
  logic signed [imhit_pkg::PROD_W-1:0]  r_sq;

  logic                                 is_rect_q, rect_hit_q, r_neg_q;
  logic [imhit_pkg::SQ_W-1:0]           dx_sq_q, dy_sq_q, r_sq_q;
  logic [imhit_pkg::SQ_W:0]             dist_sq;
  logic                                 hit_d, hit_q;

  assign lx = (ax_i < bx_i) ? ax_i : bx_i;
  assign hx = (ax_i < bx_i) ? bx_i : ax_i;
  assign ly = (ay_i < by_i) ? ay_i : by_i;
  assign hy = (ay_i < by_i) ? by_i : ay_i;
  assign rect_hit = (point_x_i >= lx) && (point_x_i <= hx)
                 && (point_y_i >= ly) && (point_y_i <= hy);

  assign dx = $signed({point_x_i[imhit_pkg::COORD_W-1], point_x_i})
            - $signed({ax_i[imhit_pkg::COORD_W-1], ax_i});
  assign dy = $signed({point_y_i[imhit_pkg::COORD_W-1], point_y_i})
            - $signed({ay_i[imhit_pkg::COORD_W-1], ay_i});
  assign dx_sq = $signed({{imhit_pkg::DIFF_W{dx[imhit_pkg::DIFF_W-1]}}, dx})
               * $signed({{imhit_pkg::DIFF_W{dx[imhit_pkg::DIFF_W-1]}}, dx});
  assign dy_sq = $signed({{imhit_pkg::DIFF_W{dy[imhit_pkg::DIFF_W-1]}}, dy})
               * $signed({{imhit_pkg::DIFF_W{dy[imhit_pkg::DIFF_W-1]}}, dy});
  assign r_sq  = $signed({{(imhit_pkg::DIFF_W+1){bx_i[imhit_pkg::COORD_W-1]}}, bx_i})
               * $signed({{(imhit_pkg::DIFF_W+1){bx_i[imhit_pkg::COORD_W-1]}}, bx_i});

  // squares of 17-bit differences stay below 2^32
  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      is_rect_q  <= (op_i == imhit_pkg::OP_RECT);
      rect_hit_q <= rect_hit;
      r_neg_q    <= bx_i[imhit_pkg::COORD_W-1];
      dx_sq_q    <= dx_sq[imhit_pkg::SQ_W-1:0];
      dy_sq_q    <= dy_sq[imhit_pkg::SQ_W-1:0];
      r_sq_q     <= r_sq[imhit_pkg::SQ_W-1:0];
    end
  end

  assign dist_sq = {1'b0, dx_sq_q} + {1'b0, dy_sq_q};
  assign hit_d   = is_rect_q ? rect_hit_q
                             : (!r_neg_q && (dist_sq <= {1'b0, r_sq_q}));

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

### rtl/imhit_match.sv
// ----------------------------------------------------------------------------
// imhit_match
// Match and parity state, last-wins update except defaults, result register.
// ----------------------------------------------------------------------------
module imhit_match (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  imhit_pkg::ctl_t               ctl_i,
  input  imhit_pkg::cross_t             cross0_i,
  input  imhit_pkg::cross_t             cross1_i,
  input  logic                          shape_hit_i,
  input  logic                          out_ready_i,
  output logic                          out_free_o,
  output logic                          out_valid_o,
  output logic                          found_o,
  output logic [imhit_pkg::ID_W-1:0]    hit_region_o,
  output logic                          from_default_o
);

  logic                       match_valid_q, match_valid_d;
  logic [imhit_pkg::ID_W-1:0] match_region_q, match_region_d;
  logic                       match_dflt_q, match_dflt_d;
  logic                       parity_q, parity_d;
  logic                       on_edge_q, on_edge_d;
  logic                       par_base, on_base, par_next, on_next;
  logic                       take, take_dflt, finish;
  logic                       out_valid_q, out_valid_d;
  logic                       found_q;
  logic [imhit_pkg::ID_W-1:0] hit_region_q;
  logic                       from_default_q;

  assign par_base = ctl_i.poly_start ? 1'b0 : parity_q;
  assign on_base  = ctl_i.poly_start ? 1'b0 : on_edge_q;
  // once on an edge the parity no longer matters
  assign on_next  = on_base | cross0_i.on_line | cross1_i.on_line;
  assign par_next = par_base ^ cross0_i.toggle ^ cross1_i.toggle;

  always_comb begin
    take      = 1'b0;
    take_dflt = 1'b0;
    finish    = 1'b0;
    case (ctl_i.op)
      imhit_pkg::OP_DEFAULT: begin
        take      = !match_valid_q;
        take_dflt = 1'b1;
      end
      imhit_pkg::OP_RECT,
      imhit_pkg::OP_CIRCLE: begin
        take = shape_hit_i;
      end
      imhit_pkg::OP_VERTEX: begin
        take = ctl_i.last && (on_next || par_next);
      end
      imhit_pkg::OP_FINISH: begin
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    match_valid_d  = match_valid_q;
    match_region_d = match_region_q;
    match_dflt_d   = match_dflt_q;
    parity_d       = parity_q;
    on_edge_d      = on_edge_q;
    if (fire_i) begin
      if (ctl_i.op == imhit_pkg::OP_VERTEX) begin
        parity_d  = par_next;
        on_edge_d = on_next;
      end
      if (take) begin
        match_valid_d  = 1'b1;
        match_region_d = ctl_i.id;
        match_dflt_d   = take_dflt;
      end else if (finish) begin
        match_valid_d  = 1'b0;
        match_region_d = '0;
        match_dflt_d   = 1'b0;
      end
    end
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire_i && finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_valid_q  <= 1'b0;
      match_region_q <= '0;
      match_dflt_q   <= 1'b0;
      parity_q       <= 1'b0;
      on_edge_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      match_valid_q  <= match_valid_d;
      match_region_q <= match_region_d;
      match_dflt_q   <= match_dflt_d;
      parity_q       <= parity_d;
      on_edge_q      <= on_edge_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && finish) begin
      found_q        <= match_valid_q;
      hit_region_q   <= match_valid_q ? match_region_q : '0;
      from_default_q <= match_valid_q && match_dflt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign hit_region_o   = hit_region_q;
  assign from_default_o = from_default_q;

endmodule
